// ----- hdl/wlan_to_ethernet_frame_convert_core_assert.svh -----
// Assertion macros shared by the frame converter modules
`ifndef WLAN_TO_ETHERNET_FRAME_CONVERT_CORE_ASSERT_SVH
`define WLAN_TO_ETHERNET_FRAME_CONVERT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define W2E_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define W2E_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/w2e_pkg.sv -----
// Shared types and constants of the 802.11 to Ethernet frame converter
`default_nettype none
package w2e_pkg;

   localparam int SEQ_DEPTH   = 28;
   localparam int LOOK_DEPTH  = 14;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_SHORT = 2'd1,
      ST_LARGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ENC_8023 = 2'd0,
      ENC_SNAP = 2'd1,
      ENC_DIX  = 2'd2,
      ENC_RAW  = 2'd3
   } enc_type;

   // One queued command: a run of 1 to 28 result words
   typedef struct packed {
      logic [SEQ_DEPTH-1:0][7:0] seq;
      logic [4:0]                count;
      logic                      last;
      status_type                status;
      enc_type                   enc;
   } cmd_type;

endpackage
`default_nettype wire

// ----- hdl/w2e_front.sv -----
// Front end: parses frame bytes, classifies the payload and issues commands
`default_nettype none
module w2e_front #(
   parameter int MAX_ETH_FRAME = 1514,
   parameter int LENGTH_BITS   = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic [11:0]      req_frame_length,
   input  wire logic             req_in_last,
   input  wire logic             queue_full,
   output logic                  push,
   output w2e_pkg::cmd_type      cmd
);
   import w2e_pkg::*;

   typedef enum logic [3:0] {
      PH_HEAD   = 4'b0001,
      PH_GATHER = 4'b0010,
      PH_STREAM = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   localparam logic [11:0] LEN_MASK = (LENGTH_BITS >= 12) ? 12'hfff
                                      : 12'((1 << LENGTH_BITS) - 1);
   localparam logic [13:0] MAX_LEN = 14'(MAX_ETH_FRAME);

   logic        prefix_ff;
   logic [11:0] byte_count_ff, byte_count_in;
   logic [11:0] total_ff, total_in;
   logic [2:0]  flags_ff, flags_in;
   logic [47:0] dest_ff, dest_in;
   logic [47:0] src_ff, src_in;
   logic [LOOK_DEPTH-1:0][7:0] look_ff, look_in;
   logic [11:0] pl_ff, pl_in;
   phase_type   phase_ff, phase_in;
   enc_type     enc_ff, enc_in;

   logic        accept, cmd_valid;
   logic [2:0]  pfx;
   logic [11:0] pos, h, tot_cur;
   logic [2:0]  flags_cur, flags_hdr;
   logic        in_frame, four, tods, fromds, wep;
   logic [13:0] pl_s;
   logic [5:0]  hs;
   logic [3:0]  n;
   logic [11:0] d0, s0;
   logic [11:0] look_off;
   logic        look_wr, finish;
   logic        dmatch, smatch, is_llc, big;
   enc_type     enc_cls;
   logic [11:0] pl_dec;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = queue_full;
   assign push      = accept & cmd_valid;

   // Frame position and header fields
   assign pfx       = prefix_ff ? 3'd4 : 3'd0;
   assign pos       = byte_count_ff;
   assign in_frame  = pos >= 12'(pfx);
   assign h         = pos - 12'(pfx);
   assign tot_cur   = (pos == 12'd0) ? (req_frame_length & LEN_MASK) : total_ff;
   assign flags_cur = (pos == 12'd0) ? 3'd0 : flags_ff;
   assign flags_hdr = {req_in_byte[6], req_in_byte[1], req_in_byte[0]};
   assign pl_s = 14'(tot_cur) - 14'd24 - 14'(pfx)
                 - ((flags_hdr[1:0] == 2'b11) ? 14'd6 : 14'd0)
                 - (flags_hdr[2] ? 14'd8 : 14'd0);

   assign tods   = flags_cur[0];
   assign fromds = flags_cur[1];
   assign wep    = flags_cur[2];
   assign four   = tods & fromds;
   assign hs     = 6'd24 + (four ? 6'd6 : 6'd0) + (wep ? 6'd4 : 6'd0);
   assign n      = (pl_ff < 12'(LOOK_DEPTH)) ? pl_ff[3:0] : 4'(LOOK_DEPTH);
   assign d0     = tods ? 12'd16 : 12'd4;
   assign s0     = four ? 12'd24 : ((!tods && fromds) ? 12'd16 : 12'd10);
   assign look_off = h - 12'(hs);
   assign look_wr  = (h >= 12'(hs)) && (look_off < 12'(n));
   assign finish   = (13'(h) + 13'd1) == (13'(hs) + 13'(n));
   assign pl_dec   = pl_ff - 12'd1;

   // Capture addresses and lookahead as the bytes pass
   always_comb begin
      dest_in = dest_ff;
      src_in  = src_ff;
      look_in = look_ff;
      if (phase_ff == PH_GATHER && in_frame) begin
         if (h >= d0 && h < d0 + 12'd6) dest_in = {dest_ff[39:0], req_in_byte};
         if (h >= s0 && h < s0 + 12'd6) src_in = {src_ff[39:0], req_in_byte};
         if (look_wr) look_in[look_off[3:0]] = req_in_byte;
      end
   end

   // Classify on the lookahead including the current byte
   assign dmatch = {look_in[0], look_in[1], look_in[2], look_in[3], look_in[4],
                    look_in[5]} == dest_in;
   assign smatch = {look_in[6], look_in[7], look_in[8], look_in[9], look_in[10],
                    look_in[11]} == src_in;
   assign is_llc = (look_in[0] == 8'haa) && (look_in[1] == 8'haa);

   always_comb begin
      enc_cls = ENC_RAW;
      if (n >= 4'd14 && !is_llc && (dmatch || smatch)) begin
         enc_cls = ENC_8023;
      end else if (n >= 4'd8 && is_llc && look_in[2] == 8'h03) begin
         enc_cls = ENC_SNAP;
         if (look_in[3] == 8'h00 && look_in[4] == 8'h00) begin
            if (look_in[5] == 8'h00) begin
               enc_cls = ({look_in[6], look_in[7]} == 16'h80f3) ? ENC_SNAP : ENC_DIX;
            end else if (look_in[5] == 8'hf8) begin
               enc_cls = ENC_DIX;
            end
         end
      end
   end

   always_comb begin
      case (enc_cls)
         ENC_8023: big = 14'(pl_ff) > MAX_LEN;
         ENC_DIX:  big = 14'(pl_ff) + 14'd6 > MAX_LEN;
         default:  big = 14'(pl_ff) + 14'd14 > MAX_LEN;
      endcase
   end

   // Next state and command per accepted byte
   always_comb begin
      total_in  = tot_cur;
      flags_in  = flags_cur;
      pl_in     = pl_ff;
      phase_in  = phase_ff;
      enc_in    = enc_ff;
      cmd_valid = 1'b0;
      cmd       = '0;
      byte_count_in = (pos != 12'hfff) ? pos + 12'd1 : pos;

      unique case (phase_ff)
         PH_HEAD: begin
            if (in_frame && h == 12'd1) begin
               flags_in = flags_hdr;
               if (pl_s[13]) begin
                  cmd_valid  = 1'b1;
                  cmd.count  = 5'd1;
                  cmd.last   = 1'b1;
                  cmd.status = ST_SHORT;
                  cmd.enc    = ENC_8023;
                  phase_in   = PH_DONE;
               end else begin
                  pl_in    = pl_s[11:0];
                  phase_in = PH_GATHER;
               end
            end
         end
         PH_GATHER: begin
            if (in_frame && finish) begin
               enc_in    = enc_cls;
               cmd_valid = 1'b1;
               cmd.enc   = enc_cls;
               cmd.status = ST_DATA;
               if (big) begin
                  cmd.count  = 5'd1;
                  cmd.last   = 1'b1;
                  cmd.status = ST_LARGE;
                  phase_in   = PH_DONE;
               end else begin
                  if (enc_cls == ENC_8023) begin
                     for (int i = 0; i < LOOK_DEPTH; i++) cmd.seq[i] = look_in[i];
                     cmd.count = 5'(n);
                  end else begin
                     for (int i = 0; i < 6; i++) begin
                        cmd.seq[i]     = dest_in[47-8*i -: 8];
                        cmd.seq[6 + i] = src_in[47-8*i -: 8];
                     end
                     if (enc_cls == ENC_DIX) begin
                        cmd.seq[12] = look_in[6];
                        cmd.seq[13] = look_in[7];
                        for (int i = 0; i < 6; i++) cmd.seq[14 + i] = look_in[8 + i];
                        cmd.count = 5'd6 + 5'(n);
                     end else begin
                        cmd.seq[12] = {4'd0, pl_ff[11:8]};
                        cmd.seq[13] = pl_ff[7:0];
                        for (int i = 0; i < LOOK_DEPTH; i++) cmd.seq[14 + i] = look_in[i];
                        cmd.count = 5'd14 + 5'(n);
                     end
                  end
                  pl_in    = pl_ff - 12'(n);
                  cmd.last = (pl_ff == 12'(n));
                  phase_in = (pl_ff == 12'(n)) ? PH_DONE : PH_STREAM;
               end
            end
         end
         PH_STREAM: begin
            pl_in      = pl_dec;
            cmd_valid  = 1'b1;
            cmd.seq[0] = req_in_byte;
            cmd.count  = 5'd1;
            cmd.last   = (pl_dec == 12'd0);
            cmd.status = ST_DATA;
            cmd.enc    = enc_ff;
            if (pl_dec == 12'd0) phase_in = PH_DONE;
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      // Frame end: replace an unfinished frame's output with a drop
      if (req_in_last) begin
         if (phase_in != PH_DONE) begin
            cmd_valid  = 1'b1;
            cmd        = '0;
            cmd.count  = 5'd1;
            cmd.last   = 1'b1;
            cmd.status = ST_SHORT;
            cmd.enc    = ENC_8023;
         end
         phase_in      = PH_HEAD;
         byte_count_in = 12'd0;
      end
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= 1'b0;
      end else if (csr_write_enable) begin
         prefix_ff <= csr_write_data;
      end
   end

   // Advance parser state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         total_ff      <= '0;
         flags_ff      <= '0;
         dest_ff       <= '0;
         src_ff        <= '0;
         pl_ff         <= '0;
         phase_ff      <= PH_HEAD;
         enc_ff        <= ENC_8023;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         total_ff      <= total_in;
         flags_ff      <= flags_in;
         dest_ff       <= dest_in;
         src_ff        <= src_in;
         pl_ff         <= pl_in;
         phase_ff      <= phase_in;
         enc_ff        <= enc_in;
      end
   end

   // Lookahead bytes
   always_ff @(posedge clock) begin
      if (accept) look_ff <= look_in;
   end

endmodule
`default_nettype wire

// ----- hdl/w2e_queue.sv -----
// Two-entry command queue between the front and back ends
`default_nettype none
module w2e_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  w2e_pkg::cmd_type  push_cmd,
   input  wire logic         pop,
   output logic              full,
   output logic              not_empty,
   output w2e_pkg::cmd_type  head
);
   import w2e_pkg::*;
`include "wlan_to_ethernet_frame_convert_core_assert.svh"

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      if (!push && pop) cnt_in = cnt_ff - 2'd1;
   end

   // Track occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_in;
      end
   end

   // Store commands
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   `W2E_ASSERT_NOW(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `W2E_ASSERT_NOW(a_no_underflow, clock, reset, pop, not_empty, "pop from empty queue")
   `W2E_ASSERT_NEXT(a_fill, clock, reset, push && !pop, cnt_ff == 2'($past(cnt_ff) + 2'd1), "count did not rise")

endmodule
`default_nettype wire

// ----- hdl/w2e_back.sv -----
// Back end: expands queued commands into result words through an output register
`default_nettype none
module w2e_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         not_empty,
   input  w2e_pkg::cmd_type  head,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_last,
   output logic [1:0]        rsp_status,
   output logic [1:0]        rsp_encoding
);
   import w2e_pkg::*;
`include "wlan_to_ethernet_frame_convert_core_assert.svh"

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   status_type status_ff;
   enc_type    enc_ff;
   logic [4:0] idx_ff;
   logic       load, final_word;

   assign load       = not_empty && (!valid_ff || !rsp_stall);
   assign final_word = idx_ff == head.count - 5'd1;
   assign pop        = load && final_word;

   // Step through the command's words
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 5'd0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
         if (load) idx_ff <= final_word ? 5'd0 : idx_ff + 5'd1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head.seq[idx_ff];
         last_ff   <= head.last && final_word;
         status_ff <= head.status;
         enc_ff    <= head.enc;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;
   assign rsp_status   = status_ff;
   assign rsp_encoding = enc_ff;

   `W2E_ASSERT_NOW(a_drop_is_last, clock, reset, valid_ff && status_ff != ST_DATA, last_ff, "drop word not last")
   `W2E_ASSERT_NOW(a_idx_range, clock, reset, not_empty, idx_ff < head.count, "index beyond command")
   `W2E_ASSERT_NEXT(a_pop_rewinds, clock, reset, pop, idx_ff == 5'd0, "index not rewound")

endmodule
`default_nettype wire

// ----- hdl/wlan_to_ethernet_frame_convert_core.sv -----
// Top level of the 802.11 to Ethernet frame converter
//
//   channel | direction | handshake          | words
//   req_    | in        | req_valid/stall    | frame bytes, length, last flag
//   rsp_    | out       | rsp_valid/stall    | Ethernet bytes, last, status, encoding
//   csr_    | in        | csr_write_enable   | prefix_present
//
// One frame byte is taken per cycle unless the queue is full; its first result word
// goes into the queue as the byte is taken, then into the output register.
// The header burst at classification (up to 28 words) drains from the back end at
// one word per cycle while rsp_stall is low; the two-entry command queue stalls
// req_ while it is full. Reset clears parser state, queue occupancy and output valid.
// rsp_stall holds the output register; req_stall depends only on queue fill.
`default_nettype none
module wlan_to_ethernet_frame_convert_core #(
   parameter int MAX_ETH_FRAME = 1514,
   parameter int LENGTH_BITS   = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic [11:0] req_frame_length,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_encoding
);
   import w2e_pkg::*;

   cmd_type push_cmd, head;
   logic    push, pop, full, not_empty;

   w2e_front #(
      .MAX_ETH_FRAME(MAX_ETH_FRAME),
      .LENGTH_BITS  (LENGTH_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_frame_length (req_frame_length),
      .req_in_last      (req_in_last),
      .queue_full       (full),
      .push             (push),
      .cmd              (push_cmd)
   );

   w2e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   w2e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .not_empty    (not_empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_status   (rsp_status),
      .rsp_encoding (rsp_encoding)
   );

endmodule
`default_nettype wire
